// ===== hdl/cvr_pkg.sv =====
// Shared constants for the vertex clip unit.
package cvr_pkg;

  localparam int REG_BITS     = 12;  // max_x / max_y and snapped result width
  localparam int PREV_BITS    = 20;  // previous vertex coordinate width
  localparam int CFG_IDX_BITS = 1;

  localparam logic [REG_BITS-1:0] REG_RESET = {REG_BITS{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_X = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_Y = 1'b1;

endpackage

// ===== hdl/cvr_if.sv =====
// Request and result channel interfaces for the vertex clip unit.
interface cvr_in_if #(
  parameter int COORD_BITS = 24
) ();
  import cvr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic        [PREV_BITS-1:0]  prev_x;
  logic        [PREV_BITS-1:0]  prev_y;

  modport source (output valid, output point_x, output point_y, output prev_x,
                  output prev_y, input ready);
  modport sink   (input valid, input point_x, input point_y, input prev_x,
                  input prev_y, output ready);
endinterface

interface cvr_out_if ();
  import cvr_pkg::*;

  logic                valid;
  logic                ready;
  logic [REG_BITS-1:0] snapped_x;
  logic [REG_BITS-1:0] snapped_y;
  logic                was_clipped;

  modport source (output valid, output snapped_x, output snapped_y,
                  output was_clipped, input ready);
  modport sink   (input valid, input snapped_x, input snapped_y,
                  input was_clipped, output ready);
endinterface

// ===== hdl/cvr_muldiv.sv =====
// Bit-serial multiply-then-divide unit on magnitudes: q = (a * b) / d.
module cvr_muldiv #(
  parameter int OPW = 26,
  parameter int DW  = 55
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [OPW-1:0]       a_mag,
  input  logic [OPW-1:0]       b_mag,
  input  logic [DW-1:0]        d_mag,
  output logic                 done,
  output logic [2*OPW-1:0]     q_mag
);
  import cvr_pkg::*;

  localparam int PW = 2 * OPW;
  localparam int CW = $clog2(PW);

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_MUL  = 3'b010,
    M_DIV  = 3'b100
  } md_state_t;

  md_state_t         state_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [OPW-1:0]    a_r;
  logic [PW-1:0]     b_r;
  logic [PW-1:0]     acc_r;   // product, then quotient shifted in
  logic [DW-1:0]     d_r;
  logic [DW-1:0]     rem_r;

  logic [DW:0]       trial;
  logic [DW:0]       diff;
  logic              ge;

  // one restoring division step
  always_comb begin
    trial = {rem_r, acc_r[PW-1]};
    diff  = trial - {1'b0, d_r};
    ge    = (trial >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (start) begin
            state_r <= M_MUL;
            cnt_r   <= '0;
          end
        end
        M_MUL: begin
          if (cnt_r == CW'(OPW - 1)) begin
            state_r <= M_DIV;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        M_DIV: begin
          if (cnt_r == CW'(PW - 1)) begin
            state_r <= M_IDLE;
            done_r  <= 1'b1;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    case (state_r)
      M_IDLE: begin
        if (start) begin
          a_r   <= a_mag;
          b_r   <= PW'(b_mag);
          d_r   <= d_mag;
          acc_r <= '0;
          rem_r <= '0;
        end
      end
      M_MUL: begin
        if (a_r[0]) acc_r <= acc_r + b_r;
        a_r <= a_r >> 1;
        b_r <= b_r << 1;
      end
      M_DIV: begin
        rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
        acc_r <= {acc_r[PW-2:0], ge};
      end
      default: ;
    endcase
  end

  assign done  = done_r;
  assign q_mag = acc_r;

endmodule

// ===== hdl/clip_vertex_to_rectangle_unit.sv =====
// Top level of the vertex clip unit: control, clamp passes and result register.
//
// Clips a new polygon vertex (signed fixed point, FRAC_BITS fraction bits) onto
// the rectangle [0, max_x] x [0, max_y] by sliding it along the line to the
// previous vertex, then truncates the result to integer cells. One request is
// processed at a time; in_ch.ready is high only while the unit is idle. A
// request inside the rectangle steps through the x pass, the y pass and the done
// state into the result register, and the next request is taken once the unit is
// back in idle. Each clamp pass that has to move the other coordinate runs the
// shared bit-serial multiply/divide unit once, on AW-bit multiply operands, where
// AW = max(12 + FRAC_BITS, 20, COORD_BITS) + 2. Worst case is two such passes.
// The result sits in an output register, so a finished result can wait for
// out_ch.ready while the unit takes the next request. max_x and max_y reset to
// 4095; the user must write them through the cfg_ port (index 0 = max_x,
// 1 = max_y) only while the unit is idle; the unit itself does not enforce it.
module clip_vertex_to_rectangle_unit #(
  parameter int FRAC_BITS  = 8,
  parameter int COORD_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cvr_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [cvr_pkg::REG_BITS-1:0]      cfg_wdata,
  cvr_in_if.sink                            in_ch,
  cvr_out_if.source                         out_ch
);
  import cvr_pkg::*;

  // Width plan: AW holds any coordinate difference, PW the product, WW all
  // working coordinates including a quotient added to a previous vertex.
  localparam int HW  = REG_BITS + FRAC_BITS;
  localparam int MW0 = (HW > PREV_BITS) ? HW : PREV_BITS;
  localparam int AW  = ((MW0 > COORD_BITS) ? MW0 : COORD_BITS) + 2;
  localparam int PW  = 2 * AW;
  localparam int WW  = PW + 3;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_XPASS = 6'b000010,
    S_XWAIT = 6'b000100,
    S_YPASS = 6'b001000,
    S_YWAIT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic signed [WW-1:0]  x_r, x_nxt;
  logic signed [WW-1:0]  y_r, y_nxt;
  logic [PREV_BITS-1:0]  px_r, py_r;
  logic                  clip_r, clip_nxt;
  logic                  neg_r, neg_nxt;
  logic [REG_BITS-1:0]   max_x_r, max_y_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [REG_BITS-1:0]   out_x_r, out_y_r;
  logic                  out_clip_r;

  logic                  in_acc;
  logic                  out_load;
  logic signed [WW-1:0]  hx, hy, pxw, pyw;
  logic                  is_y;
  logic signed [WW-1:0]  own, oth, pown, poth, hi;
  logic                  out_rng;
  logic signed [WW-1:0]  own_new;
  logic signed [WW-1:0]  d_a, d_b, d_d;
  logic signed [WW-1:0]  abs_a, abs_b, abs_d;
  logic                  move_ok;
  logic signed [WW-1:0]  q_s, oth_new;
  logic signed [WW-1:0]  x_sat, y_sat;

  logic                  md_start;
  logic                  md_done;
  logic [PW-1:0]         md_q;

  // --- configuration registers ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r <= REG_RESET;
      max_y_r <= REG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MAX_X: max_x_r <= cfg_wdata;
        CFG_MAX_Y: max_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --- clamp pass datapath, shared by both axes ---
  // x pass: own = x, other = y; y pass swaps them.
  assign hx  = WW'(max_x_r) << FRAC_BITS;
  assign hy  = WW'(max_y_r) << FRAC_BITS;
  assign pxw = WW'(px_r);
  assign pyw = WW'(py_r);

  assign is_y = (state_r == S_YPASS) || (state_r == S_YWAIT);

  always_comb begin
    own  = is_y ? y_r : x_r;
    oth  = is_y ? x_r : y_r;
    pown = is_y ? pyw : pxw;
    poth = is_y ? pxw : pyw;
    hi   = is_y ? hy  : hx;

    out_rng = (own < 0) || (own > hi);
    own_new = (own < 0) ? '0 : hi;

    // other = p_oth + (own_new - p_own) * (p_oth - oth) / (p_own - own)
    d_a = own_new - pown;
    d_b = poth - oth;
    d_d = pown - own;
    abs_a = d_a[WW-1] ? -d_a : d_a;
    abs_b = d_b[WW-1] ? -d_b : d_b;
    abs_d = d_d[WW-1] ? -d_d : d_d;

    // skip when the previous vertex sits on this axis' edge, the line runs
    // along this axis (other coordinate unchanged), or the divisor would be zero
    move_ok = (pown != '0) && (pown != hi) && (d_b != '0) && (d_d != '0);

    // quotient truncates toward zero: sign applied to the magnitude
    q_s     = neg_r ? -WW'(md_q) : WW'(md_q);
    oth_new = poth + q_s;

    x_sat = (x_r < 0) ? '0 : ((x_r > hx) ? hx : x_r);
    y_sat = (y_r < 0) ? '0 : ((y_r > hy) ? hy : y_r);
  end

  // --- control ---
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    clip_nxt  = clip_r;
    neg_nxt   = neg_r;
    md_start  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_nxt     = WW'(in_ch.point_x);
          y_nxt     = WW'(in_ch.point_y);
          clip_nxt  = 1'b0;
          state_nxt = S_XPASS;
        end
      end
      S_XPASS, S_YPASS: begin
        state_nxt = is_y ? S_DONE : S_YPASS;
        if (out_rng) begin
          clip_nxt = 1'b1;
          if (is_y) y_nxt = own_new;
          else      x_nxt = own_new;
          if (move_ok) begin
            md_start  = 1'b1;
            neg_nxt   = d_a[WW-1] ^ d_b[WW-1] ^ d_d[WW-1];
            state_nxt = is_y ? S_YWAIT : S_XWAIT;
          end
        end
      end
      S_XWAIT, S_YWAIT: begin
        if (md_done) begin
          if (is_y) x_nxt = oth_new;
          else      y_nxt = oth_new;
          state_nxt = is_y ? S_DONE : S_YPASS;
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)          out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      clip_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clip_r      <= clip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    neg_r <= neg_nxt;
    if (in_acc) begin
      px_r <= in_ch.prev_x;
      py_r <= in_ch.prev_y;
    end
    if (out_load) begin
      out_x_r    <= x_sat[FRAC_BITS +: REG_BITS];
      out_y_r    <= y_sat[FRAC_BITS +: REG_BITS];
      out_clip_r <= clip_r;
    end
  end

  // --- shared serial multiply/divide ---
  cvr_muldiv #(
    .OPW (AW),
    .DW  (WW)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a_mag (abs_a[AW-1:0]),
    .b_mag (abs_b[AW-1:0]),
    .d_mag (abs_d),
    .done  (md_done),
    .q_mag (md_q)
  );

  // --- ports ---
  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.snapped_x   = out_x_r;
  assign out_ch.snapped_y   = out_y_r;
  assign out_ch.was_clipped = out_clip_r;

  // --- checks ---
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> (state_r == S_XWAIT || state_r == S_YWAIT))
    else $error("divide result arrived outside a wait state");

  a_wait_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_XWAIT || state_r == S_YWAIT) |-> clip_r)
    else $error("line move running without a clamp");

  a_out_in_rect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_x_r <= max_x_r && out_y_r <= max_y_r))
    else $error("result lies outside the rectangle");

endmodule

// ===== tb/cvr_snap_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the vertex clip unit: predicts each snapped vertex and compares it.
module cvr_snap_checker #(
  parameter int FRAC_BITS  = 8,
  parameter int COORD_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cvr_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [cvr_pkg::REG_BITS-1:0]     cfg_wdata,
  cvr_in_if                                in_mon,
  cvr_out_if                               out_mon,
  output int                               err_count,
  output int                               pending,
  output int                               n_done,
  output int                               n_clip
);
  import cvr_pkg::*;

  typedef struct packed {
    logic [REG_BITS-1:0] sx;
    logic [REG_BITS-1:0] sy;
    logic                clipped;
  } snap_t;

  logic [REG_BITS-1:0] lim_x;
  logic [REG_BITS-1:0] lim_y;
  snap_t               snap_q[$];
  int                  errs;
  int                  done_cnt;
  int                  clip_cnt;

  // Clamp x, slide y along the line to the previous vertex, then the same for y.
  function automatic snap_t snap_vertex(input logic signed [COORD_BITS-1:0] pt_x,
                                        input logic signed [COORD_BITS-1:0] pt_y,
                                        input logic [PREV_BITS-1:0]         pv_x,
                                        input logic [PREV_BITS-1:0]         pv_y);
    longint x, y, px, py, hx, hy, x0, y0;
    snap_t  r;
    x  = longint'(pt_x);
    y  = longint'(pt_y);
    px = longint'(pv_x);
    py = longint'(pv_y);
    hx = longint'(lim_x) << FRAC_BITS;
    hy = longint'(lim_y) << FRAC_BITS;
    r.clipped = 1'b0;
    if (x < 0 || x > hx) begin
      x0 = x;
      y0 = y;
      r.clipped = 1'b1;
      x = (x < 0) ? 0 : hx;
      // skipped for horizontal lines, zero divisor, or previous vertex on an x edge
      if (px != 0 && px != hx && py != y0 && px != x0)
        y = py + ((x - px) * (py - y0)) / (px - x0);
    end
    if (y < 0 || y > hy) begin
      x0 = x;
      y0 = y;
      r.clipped = 1'b1;
      y = (y < 0) ? 0 : hy;
      if (py != 0 && py != hy && px != x0 && py != y0)
        x = px + ((y - py) * (px - x0)) / (py - y0);
    end
    // previous vertex outside the area can leave a coordinate out of range
    if (x < 0) x = 0;
    else if (x > hx) x = hx;
    if (y < 0) y = 0;
    else if (y > hy) y = hy;
    r.sx = x[FRAC_BITS +: REG_BITS];
    r.sy = y[FRAC_BITS +: REG_BITS];
    return r;
  endfunction

  always @(posedge clk) begin
    snap_t want;
    snap_t got;
    if (!rst_n) begin
      lim_x    = REG_RESET;
      lim_y    = REG_RESET;
      errs     = 0;
      done_cnt = 0;
      clip_cnt = 0;
      snap_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MAX_X: lim_x = cfg_wdata;
          CFG_MAX_Y: lim_y = cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        snap_q.push_back(snap_vertex(in_mon.point_x, in_mon.point_y,
                                     in_mon.prev_x, in_mon.prev_y));
      if (out_mon.valid && out_mon.ready) begin
        got.sx      = out_mon.snapped_x;
        got.sy      = out_mon.snapped_y;
        got.clipped = out_mon.was_clipped;
        if (snap_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("[%0t] unexpected result x=%0d y=%0d clip=%0b", $realtime,
                     got.sx, got.sy, got.clipped);
        end else begin
          want = snap_q.pop_front();
          done_cnt++;
          if (want.clipped) clip_cnt++;
          if (got !== want) begin
            errs++;
            if (errs <= 10)
              $display("[%0t] mismatch: expected x=%0d y=%0d clip=%0b, got x=%0d y=%0d clip=%0b",
                       $realtime, want.sx, want.sy, want.clipped,
                       got.sx, got.sy, got.clipped);
          end
        end
      end
    end
    err_count <= errs;
    pending   <= snap_q.size();
    n_done    <= done_cnt;
    n_clip    <= clip_cnt;
  end

endmodule

// ===== tb/clip_vertex_to_rectangle_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the vertex clip unit: request stimulus, flow control and verdict.
module clip_vertex_to_rectangle_unit_tb;
  import cvr_pkg::*;

  localparam int FRAC_BITS  = 8;
  localparam int COORD_BITS = 24;
  localparam int CELL       = 1 << FRAC_BITS;
  localparam int HMAX       = 4095 * CELL;   // far edge at reset, also fits the prev field
  // Allow for the worst request plus gaps, stalls and the hold-off, then take
  // that several times over.
  localparam int LIMIT       = 1_500_000;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 200;
  localparam int N_PHASES    = 12;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SEND_IDLE,
    FLOW_RECV_STALL,
    FLOW_BOTH
  } flow_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [REG_BITS-1:0]     cfg_wdata;

  int err_count;
  int pending;
  int n_done;
  int n_clip;
  int n_sent;
  int n_settings;
  int snd_idle;    // percent of cycles the sender sits out
  int rcv_stall;   // percent of cycles the receiver drops ready
  bit hold_go;     // asks the receiver for one long hold-off
  int cur_mx;
  int cur_my;
  int cycle_cnt = 0;

  cvr_in_if #(.COORD_BITS(COORD_BITS)) in_ch ();
  cvr_out_if                           out_ch ();

  clip_vertex_to_rectangle_unit #(
    .FRAC_BITS (FRAC_BITS),
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  cvr_snap_checker #(
    .FRAC_BITS (FRAC_BITS),
    .COORD_BITS(COORD_BITS)
  ) u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .err_count(err_count),
    .pending  (pending),
    .n_done   (n_done),
    .n_clip   (n_clip)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results in", cycle_cnt, n_done, n_sent);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one request, with random gaps before it; returns at the accepting edge.
  // valid is left high so back-to-back requests never toggle it within a step.
  task automatic send_req(input int ax, input int ay, input int bx, input int by);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.point_x <= COORD_BITS'(ax);
    in_ch.point_y <= COORD_BITS'(ay);
    in_ch.prev_x  <= PREV_BITS'(bx);
    in_ch.prev_y  <= PREV_BITS'(by);
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  // Receiver: random ready per the current stall rate, plus one long hold-off
  // while the sender keeps pushing, so the result register and the core fill up.
  initial begin
    bit held;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rcv_stall);
      end
    end
  end

  initial begin
    int                  ph, i, k, ax, ay, bx, by, hx, hy, nrand;
    flow_t               mode;
    int                  mx, my;
    bit                  write_cfg;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_MAX_X;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.prev_x  = '0;
    in_ch.prev_y  = '0;
    hold_go       = 1'b0;
    snd_idle      = 0;
    rcv_stall     = 0;
    n_sent        = 0;
    n_settings    = 1;
    cur_mx        = 4095;
    cur_my        = 4095;
    mx            = 0;
    my            = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (ph = 0; ph < N_PHASES; ph++) begin
      write_cfg = 1'b1;
      nrand     = 120;
      mode      = FLOW_FREE;
      case (ph)
        0:  begin write_cfg = 1'b0; nrand = 0; end   // reset limits, directed only
        1:  begin mx = 4095; my = 4095; end
        2:  begin mx = 1; my = 1; mode = FLOW_SEND_IDLE; end
        3:  begin mx = 20; my = 10; mode = FLOW_RECV_STALL; end
        4:  begin mx = $urandom_range(1, 4095); my = $urandom_range(1, 4095);
                  mode = FLOW_BOTH; nrand = 150; end
        5:  begin mx = 4095; my = 1; mode = FLOW_SEND_IDLE; end
        6:  begin mx = 1; my = 4095; mode = FLOW_RECV_STALL; end
        7:  begin mx = 0; my = 0; nrand = 20; end    // degenerate area at the origin
        8:  begin mx = $urandom_range(1, 4095); my = $urandom_range(1, 4095); nrand = 150; end
        9:  begin mx = $urandom_range(1, 64); my = $urandom_range(1, 64);
                  mode = FLOW_BOTH; nrand = 150; end
        10: begin mx = $urandom_range(1, 4095); my = $urandom_range(1, 4095);
                  mode = FLOW_RECV_STALL; nrand = 140; end
        default: begin mx = $urandom_range(1, 4095); my = $urandom_range(1, 4095);
                  mode = FLOW_SEND_IDLE; nrand = 140; end
      endcase

      // Limits change only with the unit idle: every result is in at this point.
      if (write_cfg) begin
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_MAX_X;
        cfg_wdata <= REG_BITS'(mx);
        @(posedge clk);
        cfg_idx   <= CFG_MAX_Y;
        cfg_wdata <= REG_BITS'(my);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_mx = mx;
        cur_my = my;
        n_settings++;
      end

      case (mode)
        FLOW_SEND_IDLE:  begin snd_idle = 81; rcv_stall = 0;  end
        FLOW_RECV_STALL: begin snd_idle = 0;  rcv_stall = 81; end
        FLOW_BOTH:       begin snd_idle = 26; rcv_stall = 26; end
        default:         begin snd_idle = 0;  rcv_stall = 0;  end
      endcase
      if (ph == 4) hold_go = 1'b1;

      hx = cur_mx * CELL;
      hy = cur_my * CELL;

      // Directed requests: point_x, point_y, prev_x, prev_y
      if (ph == 0) begin
        send_req(1000 * CELL + 17, 2000 * CELL + 200, 5 * CELL, 7 * CELL);  // inside
        send_req(0, 0, 0, 0);                                                // origin
        send_req(HMAX, HMAX, HMAX, HMAX);                                    // far corner
        send_req(HMAX + 1, 500 * CELL, 2000 * CELL, 1000 * CELL);            // just past x
        send_req(-1, 300 * CELL, 100 * CELL, 200 * CELL);                    // just below x
        send_req(123 * CELL + 45, -1, 77 * CELL, 88 * CELL);                 // just below y
        send_req(32'h7FFFFF, 32'h7FFFFF, 2048 * CELL, 1024 * CELL);          // field maxima
        send_req(32'h800000, 32'h800000, 1000 * CELL + 55, 3000 * CELL + 99);// field minima
        send_req(32'h7FFFFF, 32'h800000, 1, HMAX - 1);
        send_req(32'h555555, 32'hAAAAAA, 32'hAAAAA, 32'h55555);
        send_req(32'hAAAAAA, 32'h555555, 32'h55555, 32'hAAAAA);
        send_req(-5000, 700 * CELL, 300 * CELL, 700 * CELL);                 // horizontal
        send_req(900 * CELL, HMAX + 40000, 900 * CELL, 100 * CELL);          // vertical
        send_req(-300, 1000 * CELL, 0, 500 * CELL);                          // prev on x=0
        send_req(HMAX + 300, 1000 * CELL, HMAX, 500 * CELL);                 // prev on far x
        send_req(1000 * CELL, -900, 500 * CELL, 0);                          // prev on y=0
        send_req(1000 * CELL, HMAX + 900, 500 * CELL, HMAX);                 // prev on far y
        send_req(-100000, -300000, 10 * CELL, 10 * CELL);                    // two passes
        send_req(HMAX + 200000, HMAX + 50000, 4000 * CELL, 4000 * CELL);
        send_req(-2000000, 100 * CELL, 5 * CELL, 3000 * CELL);               // x pass moves y, y stays inside
      end else if (ph == 3) begin
        // small area: previous vertex can lie outside it
        send_req(100, 100, HMAX, HMAX);                // point inside, prev outside
        send_req(6000, 1000, 6000, 2000);              // x pass, zero divisor
        send_req(1000, 3000, 500, 3000);               // y pass, zero divisor
        send_req(-500, -500, 9000, 9000);              // x pass moves y onto y = 0
        send_req(7000, -300, 20000, 30000);
      end else if (ph == 7) begin
        send_req(0, 0, 0, 0);
        send_req(5, 5, 0, 0);
        send_req(-5, -5, 300, 200);
      end

      // Random requests: mostly a previous vertex inside the area and a new one
      // around it, some with the previous vertex anywhere from 0 to HMAX.
      for (i = 0; i < nrand; i++) begin
        if ($urandom_range(0, 99) < 15) begin
          bx = $urandom_range(0, HMAX);
          by = $urandom_range(0, HMAX);
        end else begin
          bx = $urandom_range(0, hx);
          by = $urandom_range(0, hy);
          k = $urandom_range(0, 11);
          if (k == 0)      bx = 0;
          else if (k == 1) bx = hx;
          else if (k == 2) by = 0;
          else if (k == 3) by = hy;
        end
        k = $urandom_range(0, 9);
        if (k < 2) begin
          ax = $urandom_range(0, hx);
          ay = $urandom_range(0, hy);
        end else if (k == 2) begin
          ax = $urandom();
          ay = $urandom();
        end else begin
          ax = int'($urandom_range(0, 3 * hx + 1024)) - hx - 512;
          ay = int'($urandom_range(0, 3 * hy + 1024)) - hy - 512;
        end
        k = $urandom_range(0, 15);
        if (k == 0)      ay = by;   // horizontal line
        else if (k == 1) ax = bx;   // vertical line
        send_req(ax, ay, bx, by);
      end

      in_ch.valid <= 1'b0;
      while (n_done != n_sent) @(posedge clk);
      repeat (4) @(posedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d requests (%0d clipped) over %0d area settings, edges and zero size",
             n_done, n_clip, n_settings);
    $display("included, under free flow, sender gaps, receiver stalls and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cvr_pkg.sv
hdl/cvr_if.sv
hdl/cvr_muldiv.sv
hdl/clip_vertex_to_rectangle_unit.sv
tb/cvr_snap_checker.sv
tb/clip_vertex_to_rectangle_unit_tb.sv
